### hw/rtl/swept_circle_hit_test_top_macros.svh
// Assertion macros for the swept circle hit test block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SWEPT_CIRCLE_HIT_TEST_TOP_MACROS_SVH
`define SWEPT_CIRCLE_HIT_TEST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/scht_pkg.sv
// Package for the swept circle hit test block: payload types and constants.
// No dependencies.
`default_nettype none
package scht_pkg;

  localparam int CoordBits    = 24;
  localparam int ProdBits     = 2 * CoordBits;
  localparam int D2Bits       = ProdBits + 1;
  localparam int SqSteps      = (D2Bits + 1) / 2;
  localparam int SqNBits      = 2 * SqSteps;
  localparam int SqRootBits   = SqSteps;
  localparam int SqRemBits    = SqSteps + 2;
  localparam int DvRemBits    = D2Bits + 1;
  localparam int FractionBits = 17;
  localparam int SepBits      = 24;
  localparam logic [D2Bits-1:0]  MotionEps = D2Bits'(6);
  localparam logic [SepBits-1:0] SepMax    = {SepBits{1'b1}};

  // How the projection fraction is formed.
  localparam logic [1:0] TselDiv  = 2'd0;
  localparam logic [1:0] TselZero = 2'd1;
  localparam logic [1:0] TselOne  = 2'd2;

  typedef struct packed {
    logic signed [CoordBits-1:0] rel_x;
    logic signed [CoordBits-1:0] rel_y;
    logic signed [CoordBits-1:0] motion_x;
    logic signed [CoordBits-1:0] motion_y;
    logic signed [CoordBits-1:0] rad_sum;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic [FractionBits-1:0] fraction;
    logic [SepBits-1:0]      separation;
  } out_t;

  // Data that rides along the iteration chain.
  typedef struct packed {
    logic signed [CoordBits-1:0] rel_x;
    logic signed [CoordBits-1:0] rel_y;
    logic                        mx_neg;
    logic                        my_neg;
    logic [CoordBits-1:0]        amx;
    logic [CoordBits-1:0]        amy;
    logic [CoordBits-1:0]        rad;
    logic [ProdBits-1:0]         rad2;
    logic                        start_in;
    logic                        tiny;
    logic [1:0]                  tsel;
  } side_t;

endpackage
`default_nettype wire

### hw/rtl/scht_cell.sv
// One cell of the iteration chain: a square root digit step and a
// restoring division step. Depends on scht_pkg.
`default_nettype none
module scht_cell
  import scht_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter bit SQ_EN     = 1'b1,
  parameter bit DV_EN     = 1'b1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  v_i,
  input  wire side_t                 side_i,
  input  wire logic [SqNBits-1:0]    sq_n_i,
  input  wire logic [SqRemBits-1:0]  sq_rem_i,
  input  wire logic [SqRootBits-1:0] sq_root_i,
  input  wire logic [DvRemBits-1:0]  dv_rem_i,
  input  wire logic [D2Bits-1:0]     dv_m2_i,
  input  wire logic [FRAC_BITS-1:0]  dv_q_i,
  output logic                       v_o,
  output side_t                      side_o,
  output logic [SqNBits-1:0]         sq_n_o,
  output logic [SqRemBits-1:0]       sq_rem_o,
  output logic [SqRootBits-1:0]      sq_root_o,
  output logic [DvRemBits-1:0]       dv_rem_o,
  output logic [D2Bits-1:0]          dv_m2_o,
  output logic [FRAC_BITS-1:0]       dv_q_o
);

  logic [SqNBits-1:0]    sq_n_nxt;
  logic [SqRemBits-1:0]  sq_rem_nxt;
  logic [SqRootBits-1:0] sq_root_nxt;
  logic [DvRemBits-1:0]  dv_rem_nxt;
  logic [FRAC_BITS-1:0]  dv_q_nxt;

  generate
    if (SQ_EN) begin : g_sq
      logic [SqRemBits-1:0] rem_sh;
      logic [SqRemBits-1:0] trial;
      logic                 ge;
      always_comb begin
        rem_sh      = {sq_rem_i[SqRemBits-3:0], sq_n_i[SqNBits-1 -: 2]};
        trial       = {sq_root_i, 2'b01};
        ge          = (rem_sh >= trial);
        sq_rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
        sq_root_nxt = {sq_root_i[SqRootBits-2:0], ge};
        sq_n_nxt    = {sq_n_i[SqNBits-3:0], 2'b00};
      end
    end else begin : g_sq_pass
      always_comb begin
        sq_rem_nxt  = sq_rem_i;
        sq_root_nxt = sq_root_i;
        sq_n_nxt    = sq_n_i;
      end
    end

    if (DV_EN) begin : g_dv
      logic [DvRemBits-1:0] rem_sh;
      logic                 ge;
      always_comb begin
        rem_sh     = {dv_rem_i[DvRemBits-2:0], 1'b0};
        ge         = (rem_sh >= {1'b0, dv_m2_i});
        dv_rem_nxt = ge ? (rem_sh - {1'b0, dv_m2_i}) : rem_sh;
        dv_q_nxt   = {dv_q_i[FRAC_BITS-2:0], ge};
      end
    end else begin : g_dv_pass
      always_comb begin
        dv_rem_nxt = dv_rem_i;
        dv_q_nxt   = dv_q_i;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (adv) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_o    <= side_i;
      sq_n_o    <= sq_n_nxt;
      sq_rem_o  <= sq_rem_nxt;
      sq_root_o <= sq_root_nxt;
      dv_rem_o  <= dv_rem_nxt;
      dv_m2_o   <= dv_m2_i;
      dv_q_o    <= dv_q_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/scht_front.sv
// Front stages: magnitudes, products, sums and the chain start values.
// Depends on scht_pkg.
`default_nettype none
module scht_front
  import scht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              v_i,
  input  wire in_t               in_i,
  output logic                   v_o,
  output side_t                  side_o,
  output logic [SqNBits-1:0]     sq_n_o,
  output logic [DvRemBits-1:0]   dv_rem_o,
  output logic [D2Bits-1:0]      dv_m2_o
);

  function automatic logic [CoordBits-1:0] mag(input logic signed [CoordBits-1:0] a);
    mag = a[CoordBits-1] ? (~a + 1'b1) : a;
  endfunction

  // Stage 1
  logic s1_v_r;
  logic signed [CoordBits-1:0] s1_rx_r, s1_ry_r;
  logic s1_mxn_r, s1_myn_r;
  logic [CoordBits-1:0] s1_arx_r, s1_ary_r, s1_amx_r, s1_amy_r, s1_rad_r;
  // Stage 2
  logic s2_v_r;
  logic signed [CoordBits-1:0] s2_rx_r, s2_ry_r;
  logic s2_mxn_r, s2_myn_r, s2_xsame_r, s2_ysame_r;
  logic [CoordBits-1:0] s2_amx_r, s2_amy_r, s2_rad_r;
  logic [ProdBits-1:0] s2_ax2_r, s2_ay2_r, s2_mx2_r, s2_my2_r, s2_r2_r, s2_pxm_r, s2_pym_r;
  // Stage 3
  logic s3_v_r;
  side_t s3_side_r;
  logic [D2Bits-1:0] s3_d2_r, s3_m2_r, s3_pos_r, s3_neg_r;
  // Stage 4
  logic s4_v_r;
  side_t s4_side_r;
  logic [D2Bits-1:0] s4_d2_r, s4_m2_r, s4_p_r;
  logic s4_pos_gt_r;

  side_t s3_side_nxt, s4_side_nxt, s5_side_nxt;
  logic [D2Bits-1:0] pos_nxt, neg_nxt;

  always_comb begin
    s3_side_nxt          = '0;
    s3_side_nxt.rel_x    = s2_rx_r;
    s3_side_nxt.rel_y    = s2_ry_r;
    s3_side_nxt.mx_neg   = s2_mxn_r;
    s3_side_nxt.my_neg   = s2_myn_r;
    s3_side_nxt.amx      = s2_amx_r;
    s3_side_nxt.amy      = s2_amy_r;
    s3_side_nxt.rad      = s2_rad_r;
    s3_side_nxt.rad2     = s2_r2_r;
    s3_side_nxt.start_in = ({1'b0, s2_ax2_r} + {1'b0, s2_ay2_r}) <= {1'b0, s2_r2_r};
    pos_nxt = (s2_xsame_r ? {1'b0, s2_pxm_r} : '0) + (s2_ysame_r ? {1'b0, s2_pym_r} : '0);
    neg_nxt = (s2_xsame_r ? '0 : {1'b0, s2_pxm_r}) + (s2_ysame_r ? '0 : {1'b0, s2_pym_r});

    s4_side_nxt      = s3_side_r;
    s4_side_nxt.tiny = (s3_m2_r <= MotionEps);

    s5_side_nxt = s4_side_r;
    if (!s4_pos_gt_r) begin
      s5_side_nxt.tsel = TselZero;
    end else if (s4_p_r >= s4_m2_r) begin
      s5_side_nxt.tsel = TselOne;
    end else begin
      s5_side_nxt.tsel = TselDiv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      v_o    <= 1'b0;
    end else if (adv) begin
      s1_v_r <= v_i;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      v_o    <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rx_r  <= in_i.rel_x;
      s1_ry_r  <= in_i.rel_y;
      s1_mxn_r <= in_i.motion_x[CoordBits-1];
      s1_myn_r <= in_i.motion_y[CoordBits-1];
      s1_arx_r <= mag(in_i.rel_x);
      s1_ary_r <= mag(in_i.rel_y);
      s1_amx_r <= mag(in_i.motion_x);
      s1_amy_r <= mag(in_i.motion_y);
      s1_rad_r <= in_i.rad_sum[CoordBits-1] ? '0 : in_i.rad_sum;

      s2_rx_r    <= s1_rx_r;
      s2_ry_r    <= s1_ry_r;
      s2_mxn_r   <= s1_mxn_r;
      s2_myn_r   <= s1_myn_r;
      s2_xsame_r <= (s1_rx_r[CoordBits-1] == s1_mxn_r);
      s2_ysame_r <= (s1_ry_r[CoordBits-1] == s1_myn_r);
      s2_amx_r   <= s1_amx_r;
      s2_amy_r   <= s1_amy_r;
      s2_rad_r   <= s1_rad_r;
      s2_ax2_r   <= s1_arx_r * s1_arx_r;
      s2_ay2_r   <= s1_ary_r * s1_ary_r;
      s2_mx2_r   <= s1_amx_r * s1_amx_r;
      s2_my2_r   <= s1_amy_r * s1_amy_r;
      s2_r2_r    <= s1_rad_r * s1_rad_r;
      s2_pxm_r   <= s1_arx_r * s1_amx_r;
      s2_pym_r   <= s1_ary_r * s1_amy_r;

      s3_side_r <= s3_side_nxt;
      s3_d2_r   <= {1'b0, s2_ax2_r} + {1'b0, s2_ay2_r};
      s3_m2_r   <= {1'b0, s2_mx2_r} + {1'b0, s2_my2_r};
      s3_pos_r  <= pos_nxt;
      s3_neg_r  <= neg_nxt;

      s4_side_r   <= s4_side_nxt;
      s4_d2_r     <= s3_d2_r;
      s4_m2_r     <= s3_m2_r;
      s4_p_r      <= s3_pos_r - s3_neg_r;
      s4_pos_gt_r <= (s3_pos_r > s3_neg_r);

      side_o   <= s5_side_nxt;
      sq_n_o   <= SqNBits'(s4_d2_r);
      dv_m2_o  <= s4_m2_r;
      dv_rem_o <= (s5_side_nxt.tsel == TselDiv) ? {1'b0, s4_p_r} : '0;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/scht_back.sv
// Back stages: closest point, hit decision and result formatting.
// Depends on scht_pkg.
`default_nettype none
module scht_back
  import scht_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  v_i,
  input  wire side_t                 side_i,
  input  wire logic [SqRootBits-1:0] dist_i,
  input  wire logic [FRAC_BITS-1:0]  q_i,
  output logic                       v_o,
  output out_t                       res_o
);

  localparam int TBits = FRAC_BITS + 1;

  logic [TBits-1:0]              t_nxt;
  logic [CoordBits+TBits-1:0]    px_nxt, py_nxt;
  logic [SqRootBits-1:0]         diff_nxt;
  logic [SepBits-1:0]            sep_nxt;

  logic b1_v_r, b2_v_r, b3_v_r;
  side_t b1_side_r, b2_side_r, b3_side_r;
  logic [TBits-1:0] b1_t_r, b2_t_r, b3_t_r;
  logic [SepBits-1:0] b1_sep_r, b2_sep_r, b3_sep_r;
  logic [CoordBits-1:0] b1_sx_r, b1_sy_r;
  logic [CoordBits-1:0] b2_cx_r, b2_cy_r;
  logic b2_over_r, b3_over_r;
  logic [ProdBits-1:0] b3_cx2_r, b3_cy2_r;

  logic signed [CoordBits+1:0] sx_s, sy_s, cx_s, cy_s;
  logic [CoordBits+1:0] cxm, cym;
  logic [TBits+FractionBits-1:0] t_wide;
  logic hit_nxt;
  out_t res_nxt;

  always_comb begin
    unique case (side_i.tsel)
      TselZero: t_nxt = '0;
      TselOne:  t_nxt = TBits'(1) << FRAC_BITS;
      default:  t_nxt = {1'b0, q_i};
    endcase
    px_nxt   = side_i.amx * t_nxt;
    py_nxt   = side_i.amy * t_nxt;
    diff_nxt = dist_i - {1'b0, side_i.rad};
    if (dist_i <= {1'b0, side_i.rad}) begin
      sep_nxt = '0;
    end else if (diff_nxt[SqRootBits-1]) begin
      sep_nxt = SepMax;
    end else begin
      sep_nxt = diff_nxt[SepBits-1:0];
    end

    sx_s = b1_side_r.mx_neg ? -$signed({2'b00, b1_sx_r}) : $signed({2'b00, b1_sx_r});
    sy_s = b1_side_r.my_neg ? -$signed({2'b00, b1_sy_r}) : $signed({2'b00, b1_sy_r});
    cx_s = {{2{b1_side_r.rel_x[CoordBits-1]}}, b1_side_r.rel_x} - sx_s;
    cy_s = {{2{b1_side_r.rel_y[CoordBits-1]}}, b1_side_r.rel_y} - sy_s;
    cxm  = cx_s[CoordBits+1] ? (~cx_s + 1'b1) : cx_s;
    cym  = cy_s[CoordBits+1] ? (~cy_s + 1'b1) : cy_s;

    // A component larger than the radius rules out a hit before squaring.
    hit_nxt = !b3_over_r
              && (({1'b0, b3_cx2_r} + {1'b0, b3_cy2_r}) <= {1'b0, b3_side_r.rad2});
    t_wide  = {{FractionBits{1'b0}}, b3_t_r};
    res_nxt = '0;
    if (b3_side_r.start_in) begin
      res_nxt.hit = 1'b1;
    end else begin
      res_nxt.separation = b3_sep_r;
      if (!b3_side_r.tiny && hit_nxt) begin
        res_nxt.hit      = 1'b1;
        res_nxt.fraction = t_wide[FractionBits-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      v_o    <= 1'b0;
    end else if (adv) begin
      b1_v_r <= v_i;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      v_o    <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_side_r <= side_i;
      b1_t_r    <= t_nxt;
      b1_sep_r  <= sep_nxt;
      b1_sx_r   <= px_nxt[FRAC_BITS +: CoordBits];
      b1_sy_r   <= py_nxt[FRAC_BITS +: CoordBits];

      b2_side_r <= b1_side_r;
      b2_t_r    <= b1_t_r;
      b2_sep_r  <= b1_sep_r;
      b2_cx_r   <= cxm[CoordBits-1:0];
      b2_cy_r   <= cym[CoordBits-1:0];
      b2_over_r <= (cxm > {2'b00, b1_side_r.rad}) || (cym > {2'b00, b1_side_r.rad});

      b3_side_r <= b2_side_r;
      b3_t_r    <= b2_t_r;
      b3_sep_r  <= b2_sep_r;
      b3_over_r <= b2_over_r;
      b3_cx2_r  <= b2_cx_r * b2_cx_r;
      b3_cy2_r  <= b2_cy_r * b2_cy_r;

      res_o <= res_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/swept_circle_hit_test_top.sv
// Swept circle hit test: one request in, one result out, fully pipelined.
// Channels use valid/stall. A request is taken when in_valid is high and
// in_stall is low; a result is taken when out_valid is high and out_stall
// is low. Results leave in request order, one per request.
// From accepted request to out_valid a result passes 5 front stages, a chain of
// 25 cells (one square root digit per cell, one quotient bit in each of the
// first FRAC_BITS cells), 4 back stages and the output register.
// Throughput is one request per cycle while in_stall is low; the whole pipeline advances together.
// When the receiver stalls, one more result lands in a skid register; once it
// is full, in_stall rises and every stage holds until the output drains.
// Synchronous active-low reset clears all valid bits and the skid full flag;
// no clearing pass is needed and the block accepts requests right after reset.
// Depends on scht_pkg, scht_front, scht_cell, scht_back and the macros header.
`default_nettype none
module swept_circle_hit_test_top
  import scht_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int ChainLen = (SqSteps > FRAC_BITS) ? SqSteps : FRAC_BITS;

  logic adv;
  logic ch_v [0:ChainLen];
  side_t ch_side [0:ChainLen];
  logic [SqNBits-1:0]    ch_sq_n [0:ChainLen];
  logic [SqRemBits-1:0]  ch_sq_rem [0:ChainLen];
  logic [SqRootBits-1:0] ch_sq_root [0:ChainLen];
  logic [DvRemBits-1:0]  ch_dv_rem [0:ChainLen];
  logic [D2Bits-1:0]     ch_dv_m2 [0:ChainLen];
  logic [FRAC_BITS-1:0]  ch_dv_q [0:ChainLen];

  logic back_v;
  out_t back_res;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic skid_full_r, skid_full_nxt;
  out_t skid_data_r;
  logic take;

  assign adv      = !skid_full_r;
  assign in_stall = skid_full_r;

  scht_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .v_i      (in_valid),
    .in_i     (in_data),
    .v_o      (ch_v[0]),
    .side_o   (ch_side[0]),
    .sq_n_o   (ch_sq_n[0]),
    .dv_rem_o (ch_dv_rem[0]),
    .dv_m2_o  (ch_dv_m2[0])
  );

  assign ch_sq_rem[0]  = '0;
  assign ch_sq_root[0] = '0;
  assign ch_dv_q[0]    = '0;

  generate
    for (genvar i = 0; i < ChainLen; i++) begin : g_chain
      scht_cell #(
        .FRAC_BITS (FRAC_BITS),
        .SQ_EN     (i < SqSteps),
        .DV_EN     (i < FRAC_BITS)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .v_i       (ch_v[i]),
        .side_i    (ch_side[i]),
        .sq_n_i    (ch_sq_n[i]),
        .sq_rem_i  (ch_sq_rem[i]),
        .sq_root_i (ch_sq_root[i]),
        .dv_rem_i  (ch_dv_rem[i]),
        .dv_m2_i   (ch_dv_m2[i]),
        .dv_q_i    (ch_dv_q[i]),
        .v_o       (ch_v[i+1]),
        .side_o    (ch_side[i+1]),
        .sq_n_o    (ch_sq_n[i+1]),
        .sq_rem_o  (ch_sq_rem[i+1]),
        .sq_root_o (ch_sq_root[i+1]),
        .dv_rem_o  (ch_dv_rem[i+1]),
        .dv_m2_o   (ch_dv_m2[i+1]),
        .dv_q_o    (ch_dv_q[i+1])
      );
    end
  endgenerate

  scht_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .v_i    (ch_v[ChainLen]),
    .side_i (ch_side[ChainLen]),
    .dist_i (ch_sq_root[ChainLen]),
    .q_i    (ch_dv_q[ChainLen]),
    .v_o    (back_v),
    .res_o  (back_res)
  );

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_full_nxt = skid_full_r;
    if (skid_full_r) begin
      if (take) begin
        out_data_nxt  = skid_data_r;
        skid_full_nxt = 1'b0;
      end
    end else if (back_v) begin
      if (out_valid_r && !take) begin
        skid_full_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = back_res;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!skid_full_r && back_v && out_valid_r && !take) begin
      skid_data_r <= back_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "swept_circle_hit_test_top_macros.svh"

  `SCHT_ASSERT_NOW(a_skid_needs_out, skid_full_r, out_valid_r, "skid full while output empty")
  `SCHT_ASSERT_NOW(a_miss_no_frac, out_valid_r && !out_data_r.hit, out_data_r.fraction == '0, "fraction set on a miss")
  `SCHT_ASSERT_NOW(a_skid_cause, $rose(skid_full_r), $past(out_valid_r && out_stall), "skid filled without a stalled output")

endmodule
`default_nettype wire
